FILE: design/mwlfo_pkg.sv
// mwlfo_pkg: shared types and constants for the multiwave LFO.
// No dependencies; imported by every module of the block.
package mwlfo_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int WF_W       = 3;
    localparam int INC_W      = 20;
    localparam int FREQ_W     = 16;
    localparam int DEPTH_W    = 16;
    localparam int RAND_W     = 16;
    localparam int SAMPLE_W   = 18;
    localparam int LFSR_W     = 32;

    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 18;
    localparam int ACC_W   = 40;

    // Bit positions inside the accumulator
    localparam int INC_LSB    = 8;
    localparam int INC_MSB    = 35;
    localparam int INTERP_LSB = 15;
    localparam int SCALE_LSB  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIPOLAR   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_PER_HZ = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 4'd3;

    localparam logic [WF_W-1:0] WF_NONE     = 3'd0;
    localparam logic [WF_W-1:0] WF_TRIANGLE = 3'd1;
    localparam logic [WF_W-1:0] WF_UP_SAW   = 3'd2;
    localparam logic [WF_W-1:0] WF_DOWN_SAW = 3'd3;
    localparam logic [WF_W-1:0] WF_SQUARE   = 3'd4;
    localparam logic [WF_W-1:0] WF_RANDOM   = 3'd5;
    localparam logic [WF_W-1:0] WF_HOLD     = 3'd6;

    localparam logic [INC_W-1:0]  INC_RESET  = 20'd89478;
    localparam logic [LFSR_W-1:0] SEED_RESET = 32'd1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 32'h8020_0003;

    typedef struct packed {
        logic en;
        logic accum;
    } mac_ctrl_t;

    typedef struct packed {
        logic [WF_W-1:0] waveform;
        logic            bipolar;
    } wave_cfg_t;

endpackage

FILE: design/mwlfo_mac.sv
// mwlfo_mac: shared signed multiply-accumulate unit with a registered result.
// Depends on mwlfo_pkg for operand widths and the control struct.
module mwlfo_mac (
    input  logic                                  clk,
    input  mwlfo_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [mwlfo_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [mwlfo_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [mwlfo_pkg::ACC_W-1:0]    acc
);
    import mwlfo_pkg::*;

    logic signed [MUL_A_W+MUL_B_W-1:0] product;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_next;

    assign product = op_a * op_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.en)
        begin
            acc_next = (ctrl.accum ? acc_reg : '0) + ACC_W'(product);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: design/mwlfo_wave.sv
// mwlfo_wave: waveform shaper, maps phase and random values to a Q.16 level.
// Depends on mwlfo_pkg for waveform codes and widths.
module mwlfo_wave (
    input  mwlfo_pkg::wave_cfg_t                  cfg,
    input  logic [15:0]                           phase_top,
    input  logic signed [mwlfo_pkg::RAND_W-1:0]   rand_prev,
    input  logic signed [mwlfo_pkg::SAMPLE_W-1:0] interp,
    output logic signed [mwlfo_pkg::SAMPLE_W-1:0] level
);
    import mwlfo_pkg::*;

    localparam logic signed [19:0] ONE = 20'sd65536;

    logic signed [19:0] pw;
    logic signed [19:0] pw2;
    logic signed [19:0] pw4;
    logic signed [19:0] rw;
    logic signed [19:0] rw_half;
    logic signed [19:0] hold2;
    logic signed [19:0] hold_half;
    logic signed [19:0] inv;
    logic signed [19:0] val;

    always_comb
    begin
        pw        = $signed({4'b0, phase_top});
        pw2       = pw <<< 1;
        pw4       = pw <<< 2;
        inv       = ONE - pw;
        rw        = 20'(interp);
        rw_half   = (rw + ONE) >>> 1;
        hold2     = 20'(rand_prev) <<< 1;
        hold_half = (hold2 + ONE) >>> 1;
        case (cfg.waveform)
            WF_TRIANGLE:
            begin
                if (cfg.bipolar)
                    val = (!phase_top[15] ? pw4 : (inv <<< 2)) - ONE;
                else
                    val = !phase_top[15] ? pw2 : (inv <<< 1);
            end
            WF_UP_SAW:   val = cfg.bipolar ? pw2 - ONE : pw;
            WF_DOWN_SAW: val = cfg.bipolar ? ONE - pw2 : inv;
            WF_SQUARE:
            begin
                if (!phase_top[15])
                    val = ONE;
                else
                    val = cfg.bipolar ? -ONE : '0;
            end
            WF_RANDOM:   val = cfg.bipolar ? rw : rw_half;
            WF_HOLD:     val = cfg.bipolar ? hold2 : hold_half;
            default:     val = '0;
        endcase
    end

    assign level = SAMPLE_W'(val);

endmodule

FILE: design/multiwave_lfo.sv
// multiwave_lfo: top level, sequencer, phase accumulator, random source, config.
// Depends on mwlfo_pkg, mwlfo_mac and mwlfo_wave.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | input     | in_valid / in_ready  | frequency, mod_depth, block_end
//   out     | output    | out_valid / out_ready| lfo_sample, block_last
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each item steps through the increment product, the phase update, two interpolation
// products, the depth scale and the writeback; four of these use the shared multiplier.
// Reset: phase and random values clear, LFSR loads 1, registers take their defaults.
// in_ready and cfg_ready are high only in the idle state; a result waits in the output
// register while out_ready is low, and the writeback step holds until that register frees.
module multiwave_lfo #(
    parameter int PHASE_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [mwlfo_pkg::FREQ_W-1:0]           frequency,
    input  logic [mwlfo_pkg::DEPTH_W-1:0]          mod_depth,
    input  logic                                   block_end,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mwlfo_pkg::SAMPLE_W-1:0]  lfo_sample,
    output logic                                   block_last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mwlfo_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mwlfo_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import mwlfo_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INC   = 3'd1;
    localparam logic [2:0] S_PHASE = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [WF_W-1:0]            waveform_reg, waveform_next;
    logic                       bipolar_reg, bipolar_next;
    logic [INC_W-1:0]           inc_reg, inc_next;
    logic [LFSR_W-1:0]          lfsr_reg, lfsr_next;
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic signed [RAND_W-1:0]   rand_prev_reg, rand_prev_next;
    logic signed [RAND_W-1:0]   rand_next_reg, rand_next_next;
    logic [FREQ_W-1:0]          freq_reg;
    logic [DEPTH_W-1:0]         depth_reg;
    logic                       last_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       out_last_reg;

    logic                        in_xfer;
    logic                        cfg_xfer;
    logic [PHASE_BITS-1:0]       phase_inc;
    logic [PHASE_BITS:0]         phase_sum;
    logic [15:0]                 phase_top;
    logic [LFSR_W-1:0]           lfsr_shift;
    logic                        rand_wave;
    logic                        out_free;

    mac_ctrl_t                   mac_ctrl;
    logic signed [MUL_A_W-1:0]   mac_a;
    logic signed [MUL_B_W-1:0]   mac_b;
    logic signed [ACC_W-1:0]     mac_acc;
    wave_cfg_t                   wave_cfg;
    logic signed [SAMPLE_W-1:0]  level;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign phase_inc  = PHASE_BITS'(mac_acc[INC_MSB:INC_LSB]);
    assign phase_sum  = {1'b0, phase_reg} + {1'b0, phase_inc};
    assign phase_top  = phase_reg[PHASE_BITS-1 -: 16];
    assign lfsr_shift = {1'b0, lfsr_reg[LFSR_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign rand_wave  = (waveform_reg == WF_RANDOM) || (waveform_reg == WF_HOLD);

    assign wave_cfg.waveform = waveform_reg;
    assign wave_cfg.bipolar  = bipolar_reg;

    mwlfo_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (mac_acc)
    );

    mwlfo_wave u_wave (
        .cfg       (wave_cfg),
        .phase_top (phase_top),
        .rand_prev (rand_prev_reg),
        .interp    ($signed(mac_acc[INTERP_LSB+SAMPLE_W-1:INTERP_LSB])),
        .level     (level)
    );

    // Operand select for the shared multiplier
    always_comb
    begin
        mac_ctrl.en    = 1'b0;
        mac_ctrl.accum = 1'b0;
        mac_a          = '0;
        mac_b          = '0;
        unique case (state_reg)
            S_INC:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = $signed({1'b0, inc_reg});
                mac_b       = $signed({2'b0, freq_reg});
            end
            S_MUL1:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = MUL_A_W'(rand_next_reg);
                mac_b       = $signed({2'b0, phase_top});
            end
            S_MUL2:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.accum = 1'b1;
                mac_a          = MUL_A_W'(rand_prev_reg);
                mac_b          = 18'sd65536 - $signed({2'b0, phase_top});
            end
            S_SCALE:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = MUL_A_W'(level);
                mac_b       = $signed({2'b0, depth_reg});
            end
            default:
            begin
                mac_ctrl.en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        waveform_next  = waveform_reg;
        bipolar_next   = bipolar_reg;
        inc_next       = inc_reg;
        lfsr_next      = lfsr_reg;
        phase_next     = phase_reg;
        rand_prev_next = rand_prev_reg;
        rand_next_next = rand_next_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_xfer)
        begin
            unique case (cfg_index)
                CFG_WAVEFORM:   waveform_next = cfg_data[WF_W-1:0];
                CFG_BIPOLAR:    bipolar_next  = cfg_data[0];
                CFG_INC_PER_HZ: inc_next      = cfg_data[INC_W-1:0];
                CFG_SEED:       lfsr_next     = (cfg_data == '0) ? SEED_RESET : cfg_data;
                default:        inc_next      = inc_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = S_INC;
            end
            S_INC:   state_next = S_PHASE;
            S_PHASE:
            begin
                phase_next = phase_sum[PHASE_BITS-1:0];
                if (phase_sum[PHASE_BITS] && rand_wave)
                begin
                    rand_prev_next = rand_next_reg;
                    rand_next_next = $signed(lfsr_shift[LFSR_W-1 -: RAND_W]);
                    lfsr_next      = lfsr_shift;
                end
                state_next = S_MUL1;
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_SCALE;
            S_SCALE: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            waveform_reg  <= WF_NONE;
            bipolar_reg   <= 1'b1;
            inc_reg       <= INC_RESET;
            lfsr_reg      <= SEED_RESET;
            phase_reg     <= '0;
            rand_prev_reg <= '0;
            rand_next_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            waveform_reg  <= waveform_next;
            bipolar_reg   <= bipolar_next;
            inc_reg       <= inc_next;
            lfsr_reg      <= lfsr_next;
            phase_reg     <= phase_next;
            rand_prev_reg <= rand_prev_next;
            rand_next_reg <= rand_next_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on input transfer and on writeback
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            freq_reg  <= frequency;
            depth_reg <= mod_depth;
            last_reg  <= block_end;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            sample_reg   <= $signed(mac_acc[SCALE_LSB+SAMPLE_W-1:SCALE_LSB]);
            out_last_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign lfo_sample = sample_reg;
    assign block_last = out_last_reg;

`ifndef SYNTH
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("LFSR reached zero");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_INC)
        else $error("input transfer did not start the sequence");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) && !out_free |=> state_reg == S_OUT)
        else $error("writeback left while output register was full");

    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(phase_reg) |-> $past(state_reg) == S_PHASE)
        else $error("phase changed outside the phase update step");

    a_rand_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(rand_next_reg) |-> $past(state_reg) == S_PHASE)
        else $error("random value changed outside the phase update step");
`endif

endmodule

FILE: tb/lfo_sample_checker.sv
`timescale 1ns / 1ps
// lfo_sample_checker: predicts every multiwave_lfo output sample from the accepted
// input and register transfers, and compares it with the output transfers.
// Depends on mwlfo_pkg.
module lfo_sample_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [mwlfo_pkg::FREQ_W-1:0]          frequency,
    input  logic [mwlfo_pkg::DEPTH_W-1:0]         mod_depth,
    input  logic                                  block_end,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [mwlfo_pkg::SAMPLE_W-1:0] lfo_sample,
    input  logic                                  block_last,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [mwlfo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mwlfo_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                    mismatch_count,
    output int                                    samples_due
);
    import mwlfo_pkg::*;

    localparam longint UNITY = 65536;
    localparam longint HALF  = 32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } lfo_out_t;

    logic [WF_W-1:0]          wave_sel;
    logic                     bipolar_en;
    logic [INC_W-1:0]         step_per_hz;
    logic [31:0]              phase;
    logic signed [RAND_W-1:0] held_rand;
    logic signed [RAND_W-1:0] next_rand;
    logic [LFSR_W-1:0]        noise_reg;
    lfo_out_t                 expected_samples[$];

    function automatic lfo_out_t predict_sample(input logic [FREQ_W-1:0] freq,
                                                input logic [DEPTH_W-1:0] depth,
                                                input logic last);
        logic [35:0] step;
        logic [32:0] sum;
        longint      p;
        longint      h;
        longint      mix;
        longint      scaled;
        lfo_out_t    res;
        step  = freq * step_per_hz;
        sum   = phase + step[35:8];
        phase = sum[31:0];
        // advance the noise source once per wrap, for the random and hold waveforms only
        if (sum[32] && (wave_sel == WF_RANDOM || wave_sel == WF_HOLD))
        begin
            held_rand = next_rand;
            noise_reg = (noise_reg >> 1) ^ (noise_reg[0] ? LFSR_TAPS : '0);
            next_rand = noise_reg[31:16];
        end
        p = longint'({48'd0, phase[31:16]});
        case (wave_sel)
            WF_TRIANGLE:
            begin
                if (bipolar_en)
                    h = ((p < HALF) ? 4 * p : 4 * (UNITY - p)) - UNITY;
                else
                    h = (p < HALF) ? 2 * p : 2 * (UNITY - p);
            end
            WF_UP_SAW:   h = bipolar_en ? 2 * p - UNITY : p;
            WF_DOWN_SAW: h = bipolar_en ? UNITY - 2 * p : UNITY - p;
            WF_SQUARE:   h = (p < HALF) ? UNITY : (bipolar_en ? -UNITY : 0);
            WF_RANDOM:
            begin
                mix = (p * longint'(next_rand) + (UNITY - p) * longint'(held_rand)) >>> 15;
                h   = bipolar_en ? mix : (mix + UNITY) >>> 1;
            end
            WF_HOLD:
            begin
                mix = 2 * longint'(held_rand);
                h   = bipolar_en ? mix : (mix + UNITY) >>> 1;
            end
            default: h = 0;
        endcase
        scaled     = (longint'({48'd0, depth}) * h) >>> 16;
        res.sample = scaled[SAMPLE_W-1:0];
        res.last   = last;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lfo_out_t want;
        int       bad;
        if (!rst_n)
        begin
            wave_sel    = WF_NONE;
            bipolar_en  = 1'b1;
            step_per_hz = INC_RESET;
            phase       = '0;
            held_rand   = '0;
            next_rand   = '0;
            noise_reg   = SEED_RESET;
            expected_samples.delete();
            mismatch_count <= 0;
            samples_due    <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WAVEFORM:   wave_sel    = cfg_data[WF_W-1:0];
                    CFG_BIPOLAR:    bipolar_en  = cfg_data[0];
                    CFG_INC_PER_HZ: step_per_hz = cfg_data[INC_W-1:0];
                    CFG_SEED:       noise_reg   = (cfg_data != '0) ? cfg_data : 32'd1;
                    default: ;
                endcase
            end
            // compare before queueing so a same-edge input never matches itself
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("lfo_sample: unexpected transfer, got %0d", lfo_sample);
                    bad++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (lfo_sample !== want.sample)
                    begin
                        $error("lfo_sample: expected %0d, got %0d", want.sample, lfo_sample);
                        bad++;
                    end
                    if (block_last !== want.last)
                    begin
                        $error("block_last: expected %0d, got %0d", want.last, block_last);
                        bad++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_samples.push_back(predict_sample(frequency, mod_depth, block_end));
            mismatch_count <= mismatch_count + bad;
            samples_due    <= expected_samples.size();
        end
    end

endmodule

FILE: tb/multiwave_lfo_tb.sv
`timescale 1ns / 1ps
// multiwave_lfo_tb: drives multiwave_lfo with directed and random samples across
// many register settings, with random stalls on both sides, and gives the verdict.
// Depends on mwlfo_pkg, multiwave_lfo and lfo_sample_checker.
module multiwave_lfo_tb;
    import mwlfo_pkg::*;

    localparam int SAMPLE_TARGET = 1950;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_ROUND    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 4'd9;
    localparam logic [WF_W-1:0]      WF_UNDEFINED = 3'd7;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic [FREQ_W-1:0]           frequency = '0;
    logic [DEPTH_W-1:0]          mod_depth = '0;
    logic                        block_end = 1'b0;
    logic                        out_ready = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;
    wire                         in_ready;
    wire                         out_valid;
    wire signed [SAMPLE_W-1:0]   lfo_sample;
    wire                         block_last;
    wire                         cfg_ready;
    int                          mismatch_count;
    int                          samples_due;

    bit                          steady   = 1'b0;
    bit                          hold_req = 1'b0;
    int                          sent     = 0;
    logic [WF_W-1:0]             wave_codes [8];

    multiwave_lfo uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frequency  (frequency),
        .mod_depth  (mod_depth),
        .block_end  (block_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .lfo_sample (lfo_sample),
        .block_last (block_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    lfo_sample_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frequency      (frequency),
        .mod_depth      (mod_depth),
        .block_end      (block_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lfo_sample     (lfo_sample),
        .block_last     (block_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .samples_due    (samples_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_sample(input logic [FREQ_W-1:0] f, input logic [DEPTH_W-1:0] d,
                               input logic e);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        frequency <= f;
        mod_depth <= d;
        block_end <= e;
        do @(posedge clk); while (!(in_valid && in_ready));
        sent++;
    endtask

    // hold the input off until every queued sample has come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (samples_due != 0);
    endtask

    task automatic set_regs(input logic [WF_W-1:0] wf, input logic bip,
                            input logic [INC_W-1:0] inc, input bit reseed,
                            input logic [LFSR_W-1:0] seed, input bit spare);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        int                    n;
        idx[0] = CFG_WAVEFORM;
        val[0] = $urandom();
        val[0][WF_W-1:0] = wf;
        idx[1] = CFG_BIPOLAR;
        val[1] = $urandom();
        val[1][0] = bip;
        idx[2] = CFG_INC_PER_HZ;
        val[2] = $urandom();
        val[2][INC_W-1:0] = inc;
        n = 3;
        if (reseed)
        begin
            idx[n] = CFG_SEED;
            val[n] = seed;
            n++;
        end
        if (spare)
        begin
            idx[n] = CFG_SPARE;
            val[n] = $urandom();
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!(cfg_valid && cfg_ready));
        end
        cfg_valid <= 1'b0;
    endtask

    // output side: random stall per transfer, one long hold on request
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = steady ? 0 : $urandom_range(0, 7);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("multiwave_lfo_tb: FAIL");
        $finish;
    end

    initial
    begin
        logic [FREQ_W-1:0]  f;
        logic [DEPTH_W-1:0] d;
        logic [WF_W-1:0]    wf;
        logic [INC_W-1:0]   inc;
        logic [LFSR_W-1:0]  seed;
        int                 pick;
        int                 n_items;
        int                 round;
        wave_codes = '{WF_NONE, WF_TRIANGLE, WF_UP_SAW, WF_DOWN_SAW,
                       WF_SQUARE, WF_RANDOM, WF_HOLD, WF_UNDEFINED};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_sample(16'h0000, 16'h0000, 1'b1);
        send_sample(16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'h0100, 16'h8000, 1'b1);
        for (int w = 0; w < 8; w++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                drain();
                set_regs(wave_codes[w], b[0], 20'hFFFFF, b == 0,
                         (w == 0) ? 32'h0 : 32'hFFFF_FFFF, w == 0 && b == 0);
                send_sample(16'hFFFF, (b == 0) ? 16'hFFFF : 16'h0001, b[0]);
            end
        end

        round = 0;
        while (sent < SAMPLE_TARGET)
        begin
            drain();
            pick = $urandom_range(0, 11);
            wf   = (pick < 8) ? wave_codes[pick] : (pick[0] ? WF_RANDOM : WF_HOLD);
            case ($urandom_range(0, 5))
                0:       inc = '0;
                1:       inc = '1;
                2:       inc = INC_W'($urandom_range(1, 4095));
                default: inc = INC_W'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       seed = '0;
                1:       seed = '1;
                default: seed = $urandom();
            endcase
            set_regs(wf, 1'($urandom_range(0, 1)), inc, $urandom_range(0, 2) == 0, seed,
                     1'b0);
            steady = ($urandom_range(0, 3) == 0);
            if (round == HOLD_ROUND)
                hold_req = 1'b1;
            n_items = $urandom_range(10, 80);
            repeat (n_items)
            begin
                case ($urandom_range(0, 7))
                    0:       f = '0;
                    1:       f = '1;
                    2:       f = FREQ_W'($urandom_range(0, 255));
                    default: f = FREQ_W'($urandom());
                endcase
                case ($urandom_range(0, 7))
                    0:       d = '0;
                    1:       d = '1;
                    default: d = DEPTH_W'($urandom());
                endcase
                send_sample(f, d, 1'($urandom_range(0, 1)));
            end
            round++;
        end

        steady = 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && samples_due == 0)
            $display("multiwave_lfo_tb: PASS");
        else
            $display("multiwave_lfo_tb: FAIL");
        $finish;
    end

endmodule
